// ===== rtl/lsc_pkg.sv =====
// Package for the line sensor centroid block: field widths, reset values,
// payload structs, register and status codes. Depends on nothing.
`timescale 1ns / 1ps

package lsc_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_BITS  = 12;
    localparam int START_BITS   = 7;
    localparam int LIMIT_BITS   = 20;
    localparam int POS_BITS     = 7;
    localparam int TOTAL_BITS   = 19;

    // Default geometry and queue sizing
    localparam int PIXEL_COUNT_DEFAULT = 128;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Register reset values
    localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET   = 12'd275;
    localparam logic [START_BITS-1:0]  START_INDEX_RESET = 7'd4;
    localparam logic [LIMIT_BITS-1:0]  END_LIMIT_RESET   = 20'd25000;

    // Saturation limits of the result fields
    localparam logic [POS_BITS-1:0]   POS_MAX   = 7'd127;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 19'h7FFFF;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_THRESHOLD   = 2'd0,
        REG_START_INDEX = 2'd1,
        REG_END_LIMIT   = 2'd2
    } reg_index_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_LINE = 2'd0,
        STATUS_NONE = 2'd1,
        STATUS_END  = 2'd2
    } status_t;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] pixel_value;
        logic                   frame_last;
    } pixel_t;

    typedef struct packed {
        status_t                status;
        logic [POS_BITS-1:0]    line_position;
        logic [TOTAL_BITS-1:0]  intensity_total;
    } result_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] threshold;
        logic [START_BITS-1:0]  start_index;
        logic [LIMIT_BITS-1:0]  end_limit;
    } cfg_t;

endpackage

// ===== rtl/lsc_fifo.sv =====
// Small register queue with show-ahead read, used between the front and
// back parts and on the result side. Depends on lsc_pkg for the default depth.
`timescale 1ns / 1ps

module lsc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lsc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/lsc_front.sv =====
// Front part: numbers pixels, applies start index and threshold, and keeps
// the frame accumulators; hands a frame record on at the last pixel. Uses lsc_pkg.
`timescale 1ns / 1ps

module lsc_front #(
    parameter int PIXEL_COUNT = lsc_pkg::PIXEL_COUNT_DEFAULT,
    parameter int REC_W       = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lsc_pkg::cfg_t      cfg,
    input  logic               accept,
    input  lsc_pkg::pixel_t    pixel,
    output logic               rec_push,
    output logic [REC_W-1:0]   rec_data
);

    import lsc_pkg::*;

    localparam int IDX_W  = $clog2(PIXEL_COUNT + 1);
    localparam int INT_W  = SAMPLE_BITS + $clog2(PIXEL_COUNT);
    localparam int WGT_W  = SAMPLE_BITS + 2 * $clog2(PIXEL_COUNT);
    localparam int PROD_W = SAMPLE_BITS + IDX_W;
    localparam int CMP_W  = (IDX_W > START_BITS) ? IDX_W : START_BITS;

    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic [INT_W-1:0]       int_reg;
    logic [INT_W-1:0]       int_next;
    logic [WGT_W-1:0]       wgt_reg;
    logic [WGT_W-1:0]       wgt_next;
    logic                   det_reg;
    logic                   det_next;
    logic                   in_frame;
    logic                   use_pixel;
    logic [SAMPLE_BITS-1:0] level;
    logic [PROD_W-1:0]      product;

    // Position window and thresholded level
    assign in_frame  = (idx_reg < IDX_W'(PIXEL_COUNT));
    assign use_pixel = in_frame && (CMP_W'(idx_reg) >= CMP_W'(cfg.start_index));
    assign level     = (pixel.pixel_value > cfg.threshold) ?
                       (pixel.pixel_value - cfg.threshold) : '0;
    assign product   = PROD_W'(level) * PROD_W'(idx_reg);

    // Accumulator update including the current pixel
    always_comb
    begin
        int_next = int_reg;
        wgt_next = wgt_reg;
        det_next = det_reg;
        idx_next = idx_reg;
        if (use_pixel)
        begin
            int_next = int_reg + INT_W'(level);
            wgt_next = wgt_reg + WGT_W'(product);
            det_next = det_reg || (level != '0);
        end
        if (in_frame)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // The record carries the sums with the last pixel already folded in
    assign rec_push = accept && pixel.frame_last;
    assign rec_data = {det_next, int_next, wgt_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            int_reg <= '0;
            wgt_reg <= '0;
            det_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (pixel.frame_last)
            begin
                idx_reg <= '0;
                int_reg <= '0;
                wgt_reg <= '0;
                det_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_next;
                int_reg <= int_next;
                wgt_reg <= wgt_next;
                det_reg <= det_next;
            end
        end
    end

endmodule

// ===== rtl/lsc_back.sv =====
// Back part: classifies each frame record, runs a one-bit-per-cycle restoring
// divider for the centroid and forms the result. Uses lsc_pkg.
`timescale 1ns / 1ps

module lsc_back #(
    parameter int PIXEL_COUNT = lsc_pkg::PIXEL_COUNT_DEFAULT,
    parameter int REC_W       = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lsc_pkg::cfg_t        cfg,
    input  logic                 rec_empty,
    input  logic [REC_W-1:0]     rec_data,
    output logic                 rec_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output lsc_pkg::result_t     res_data
);

    import lsc_pkg::*;

    localparam int INT_W  = SAMPLE_BITS + $clog2(PIXEL_COUNT);
    localparam int WGT_W  = SAMPLE_BITS + 2 * $clog2(PIXEL_COUNT);
    localparam int Q_W    = $clog2(PIXEL_COUNT);
    localparam int STEP_W = $clog2(Q_W);
    localparam int DEN_W  = INT_W + Q_W - 1;
    localparam int DC_W   = (DEN_W > WGT_W) ? DEN_W : WGT_W;
    localparam int LIM_W  = (INT_W > LIMIT_BITS) ? INT_W : LIMIT_BITS;
    localparam int TX_W   = (INT_W > TOTAL_BITS) ? INT_W : TOTAL_BITS;
    localparam int QX_W   = (Q_W > POS_BITS) ? Q_W : POS_BITS;

    back_state_t       state_reg;
    back_state_t       state_next;
    status_t           status_reg;
    status_t           status_next;
    logic [WGT_W-1:0]  rem_reg;
    logic [WGT_W-1:0]  rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  den_next;
    logic [Q_W-1:0]    quo_reg;
    logic [Q_W-1:0]    quo_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [INT_W-1:0]  int_reg;
    logic [INT_W-1:0]  int_next;

    logic              rec_det;
    logic [INT_W-1:0]  rec_int;
    logic [WGT_W-1:0]  rec_wgt;
    logic              over_limit;
    logic              fits;
    logic [QX_W-1:0]   quo_ext;
    logic [TX_W-1:0]   int_ext;

    assign {rec_det, rec_int, rec_wgt} = rec_data;
    assign over_limit = (LIM_W'(rec_int) > LIM_W'(cfg.end_limit));
    assign fits       = (DC_W'(rem_reg) >= DC_W'(den_reg));
    assign quo_ext    = QX_W'(quo_reg);
    assign int_ext    = TX_W'(int_reg);

    // Result fields with saturation
    always_comb
    begin
        res_data.status          = status_reg;
        res_data.line_position   = '0;
        res_data.intensity_total = (int_ext > TX_W'(TOTAL_MAX)) ?
                                   TOTAL_MAX : int_ext[TOTAL_BITS-1:0];
        if (status_reg == STATUS_LINE)
        begin
            res_data.line_position = (quo_ext > QX_W'(POS_MAX)) ?
                                     POS_MAX : quo_ext[POS_BITS-1:0];
        end
    end

    // Sequencer: take a record, divide if needed, deliver the result
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        int_next    = int_reg;
        rec_pop     = 1'b0;
        res_push    = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!rec_empty)
                begin
                    rec_pop   = 1'b1;
                    int_next  = rec_int;
                    rem_next  = rec_wgt;
                    den_next  = DEN_W'(rec_int) << (Q_W - 1);
                    quo_next  = '0;
                    step_next = STEP_W'(Q_W - 1);
                    if (over_limit)
                    begin
                        status_next = STATUS_END;
                        state_next  = BK_EMIT;
                    end
                    else if (!rec_det || (rec_int == '0))
                    begin
                        status_next = STATUS_NONE;
                        state_next  = BK_EMIT;
                    end
                    else
                    begin
                        status_next = STATUS_LINE;
                        state_next  = BK_DIVIDE;
                    end
                end
            end
            BK_DIVIDE:
            begin
                if (fits)
                begin
                    rem_next = rem_reg - WGT_W'(den_reg);
                end
                quo_next  = {quo_reg[Q_W-2:0], fits};
                den_next  = den_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        int_reg    <= int_next;
    end

endmodule

// ===== rtl/line_sensor_centroid_core.sv =====
// Line sensor centroid core: one pixel transaction per cycle is accepted while the frame
// queue has room. The back part classifies each frame record taken from the frame queue,
// runs its bit-serial divider when a centroid has to be formed, and pushes the result
// into the result queue once that has room; it takes a new frame only after the result
// of the last one has been pushed.
// Reset (asynchronous, active low) empties both queues, clears the frame
// accumulators and loads the register reset values.
`timescale 1ns / 1ps

module line_sensor_centroid_core #(
    parameter int PIXEL_COUNT = lsc_pkg::PIXEL_COUNT_DEFAULT,
    parameter int QUEUE_DEPTH = lsc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    // Pixel queue side
    input  logic                push,
    output logic                full,
    input  lsc_pkg::pixel_t     pixel,
    // Result queue side
    output logic                empty,
    input  logic                pop,
    output lsc_pkg::result_t    result,
    // Register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    import lsc_pkg::*;

    localparam int INT_W = SAMPLE_BITS + $clog2(PIXEL_COUNT);
    localparam int WGT_W = SAMPLE_BITS + 2 * $clog2(PIXEL_COUNT);
    localparam int REC_W = 1 + INT_W + WGT_W;
    localparam int RES_W = $bits(result_t);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    reg_index_t       reg_sel;
    logic             cfg_write;
    logic             accept;
    logic             rec_push;
    logic [REC_W-1:0] rec_wdata;
    logic [REC_W-1:0] rec_rdata;
    logic             rec_full;
    logic             rec_empty;
    logic             rec_pop;
    logic             res_full;
    logic             res_push;
    result_t          res_wdata;
    logic [RES_W-1:0] res_rdata;

    // Register port decode
    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (reg_sel)
            REG_THRESHOLD:
            begin
                prdata = 32'(cfg_reg.threshold);
                if (cfg_write)
                begin
                    cfg_next.threshold = pwdata[SAMPLE_BITS-1:0];
                end
            end
            REG_START_INDEX:
            begin
                prdata = 32'(cfg_reg.start_index);
                if (cfg_write)
                begin
                    cfg_next.start_index = pwdata[START_BITS-1:0];
                end
            end
            REG_END_LIMIT:
            begin
                prdata = 32'(cfg_reg.end_limit);
                if (cfg_write)
                begin
                    cfg_next.end_limit = pwdata[LIMIT_BITS-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold   <= THRESHOLD_RESET;
            cfg_reg.start_index <= START_INDEX_RESET;
            cfg_reg.end_limit   <= END_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Pixel transactions are held off only while the frame queue is full
    assign full   = rec_full;
    assign accept = push && !full;

    lsc_front #(
        .PIXEL_COUNT (PIXEL_COUNT),
        .REC_W       (REC_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .accept   (accept),
        .pixel    (pixel),
        .rec_push (rec_push),
        .rec_data (rec_wdata)
    );

    // Frame records between front and back
    lsc_fifo #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_rec_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rec_push),
        .wdata (rec_wdata),
        .full  (rec_full),
        .pop   (rec_pop),
        .rdata (rec_rdata),
        .empty (rec_empty)
    );

    lsc_back #(
        .PIXEL_COUNT (PIXEL_COUNT),
        .REC_W       (REC_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .rec_empty (rec_empty),
        .rec_data  (rec_rdata),
        .rec_pop   (rec_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_wdata)
    );

    // Result queue towards the consumer
    lsc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (RES_W'(res_wdata)),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign result = result_t'(res_rdata);

endmodule

// ===== tb/line_sensor_centroid_core_tb.sv =====
// Testbench for the line sensor centroid core: pixel frames in, one centroid result out per frame.
// Depends on lsc_pkg and line_sensor_centroid_core; it is self-checking and needs no files.
`timescale 1ns / 1ps

module line_sensor_centroid_core_tb;

    import lsc_pkg::*;

    localparam int PIXELS      = PIXEL_COUNT_DEFAULT;
    localparam int SETTLE      = 24;
    localparam int IDLE_PCT    = 6;
    localparam int PHASE_ITEMS = 40;

    typedef enum int {
        SHAPE_PROFILE,
        SHAPE_NOISE,
        SHAPE_DARK,
        SHAPE_BRIGHT
    } frame_shape_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    pixel_t      pixel;
    logic        empty;
    logic        pop;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Register copies and frame accumulators of the predictor
    logic [SAMPLE_BITS-1:0] cfg_threshold;
    logic [START_BITS-1:0]  cfg_start;
    logic [LIMIT_BITS-1:0]  cfg_limit;
    int                     px_pos;
    logic [31:0]            int_sum;
    logic [39:0]            wt_sum;
    bit                     lit_seen;

    result_t expected_results[$];

    bit steady_rate;
    int errors;
    int pixels_sent;
    int frames_sent;
    int settings_used;
    int lines_seen;
    int none_seen;
    int end_seen;

    line_sensor_centroid_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .pixel   (pixel),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Fold one accepted pixel into the running frame and predict its result on the last pixel.
    task automatic track_pixel(input logic [SAMPLE_BITS-1:0] value, input logic last);
        logic [SAMPLE_BITS-1:0] level;
        logic [39:0]            quotient;
        result_t                r;
        if (px_pos < PIXELS)
        begin
            if (px_pos >= cfg_start)
            begin
                level = (value > cfg_threshold) ? value - cfg_threshold : '0;
                if (level != 0)
                    lit_seen = 1'b1;
                int_sum += level;
                wt_sum  += 40'(level) * 40'(px_pos);
            end
            px_pos++;
        end
        if (last)
        begin
            r.intensity_total = (int_sum > TOTAL_MAX) ? TOTAL_MAX : int_sum[TOTAL_BITS-1:0];
            r.line_position   = '0;
            if (int_sum > cfg_limit)
                r.status = STATUS_END;
            else if (!lit_seen || int_sum == 0)
                r.status = STATUS_NONE;
            else
            begin
                r.status        = STATUS_LINE;
                quotient        = wt_sum / int_sum;
                r.line_position = (quotient > POS_MAX) ? POS_MAX : quotient[POS_BITS-1:0];
            end
            expected_results.push_back(r);
            px_pos   = 0;
            int_sum  = '0;
            wt_sum   = '0;
            lit_seen = 1'b0;
            frames_sent++;
        end
    endtask

    // Offer one pixel and hold it until the block takes the transaction.
    task automatic send_pixel(input logic [SAMPLE_BITS-1:0] value, input logic last);
        while (!steady_rate && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        pixel <= {value, last};
        push  <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        track_pixel(value, last);
        pixels_sent++;
    endtask

    // Send a whole frame of the given length and intensity profile.
    task automatic send_frame(input int len, input frame_shape_t shape);
        int centre;
        int spread;
        int amp;
        int gap;
        int value;
        centre = $urandom_range(0, len - 1);
        spread = $urandom_range(0, 3);
        amp    = (cfg_threshold < 4095) ? $urandom_range(1, 4095 - cfg_threshold) : 0;
        for (int i = 0; i < len; i++)
        begin
            gap = (i > centre) ? i - centre : centre - i;
            case (shape)
                SHAPE_PROFILE:
                    value = (gap <= spread) ? cfg_threshold + amp / (1 + gap)
                                            : $urandom_range(0, cfg_threshold);
                SHAPE_NOISE:
                    value = $urandom_range(0, 4095);
                SHAPE_DARK:
                    value = $urandom_range(0, cfg_threshold);
                default:
                    value = 4095;
            endcase
            send_pixel(value[SAMPLE_BITS-1:0], i == len - 1);
        end
    endtask

    // Drop push and let every outstanding result drain before touching the registers.
    task automatic wait_idle();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Read a register back and compare its implemented bits.
    task automatic check_register(input reg_index_t idx, input logic [31:0] want);
        logic [31:0] mask;
        logic [31:0] got;
        case (idx)
            REG_THRESHOLD:   mask = (32'd1 << SAMPLE_BITS) - 1;
            REG_START_INDEX: mask = (32'd1 << START_BITS) - 1;
            default:         mask = (32'd1 << LIMIT_BITS) - 1;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if ((got & mask) != (want & mask))
        begin
            $error("register %s: expected %0d, actual %0d", idx.name(), want & mask, got & mask);
            errors++;
        end
    endtask

    // Write one register through a setup and an access phase, then read it back.
    task automatic program_register(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_THRESHOLD:   cfg_threshold = value[SAMPLE_BITS-1:0];
            REG_START_INDEX: cfg_start     = value[START_BITS-1:0];
            default:         cfg_limit     = value[LIMIT_BITS-1:0];
        endcase
        check_register(idx, value);
    endtask

    task automatic set_config(input int thr, input int start, input int limit);
        wait_idle();
        program_register(REG_THRESHOLD, thr);
        program_register(REG_START_INDEX, start);
        program_register(REG_END_LIMIT, limit);
        settings_used++;
    endtask

    // Result side: random back-pressure, and each popped transaction checked in order.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with none expected: status %0d position %0d total %0d",
                       result.status, result.line_position, result.intensity_total);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.status != want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, result.status);
                    errors++;
                end
                if (result.line_position != want.line_position)
                begin
                    $error("line_position: expected %0d, actual %0d",
                           want.line_position, result.line_position);
                    errors++;
                end
                if (result.intensity_total != want.intensity_total)
                begin
                    $error("intensity_total: expected %0d, actual %0d",
                           want.intensity_total, result.intensity_total);
                    errors++;
                end
                case (want.status)
                    STATUS_LINE: lines_seen++;
                    STATUS_NONE: none_seen++;
                    default:     end_seen++;
                endcase
            end
        end
        pop <= steady_rate || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic test_register_reset();
        check_register(REG_THRESHOLD, THRESHOLD_RESET);
        check_register(REG_START_INDEX, START_INDEX_RESET);
        check_register(REG_END_LIMIT, END_LIMIT_RESET);
    endtask

    // Hand-built frames under the reset settings.
    task automatic test_directed_frames();
        logic [SAMPLE_BITS-1:0] mixed[6] = '{12'd0, 12'd4095, 12'd0, 12'd0, 12'd4095, 12'd276};
        // A single bright pixel before the start index is ignored.
        send_pixel(12'd4095, 1'b1);
        // Extremes of the sample, one pixel just above the threshold.
        foreach (mixed[i])
            send_pixel(mixed[i], i == 5);
        // Pixels exactly at the threshold clamp to zero, so no line.
        for (int i = 0; i < 5; i++)
            send_pixel(THRESHOLD_RESET, i == 4);
        // Saturated pixels push the sum over the end-of-line limit.
        for (int i = 0; i < 12; i++)
            send_pixel(12'd4095, i == 11);
    endtask

    // A sum equal to the limit is still a line; one more count is end of line.
    task automatic test_limit_boundary();
        set_config(275, 4, 3820);
        for (int i = 0; i < 5; i++)
            send_pixel((i == 4) ? 12'd4095 : 12'd0, i == 4);
        for (int i = 0; i < 6; i++)
            send_pixel((i == 4) ? 12'd4095 : ((i == 5) ? 12'd276 : 12'd0), i == 5);
    endtask

    // Register extremes, including frames that run past the sensor length.
    task automatic test_register_extremes();
        set_config(0, 0, 0);
        for (int i = 0; i < 4; i++)
            send_pixel(12'd0, i == 3);
        send_frame(20, SHAPE_NOISE);
        set_config(4095, 127, 20'hFFFFF);
        send_frame(140, SHAPE_NOISE);
        set_config(0, 127, 20'hFFFFF);
        send_frame(130, SHAPE_BRIGHT);
        send_frame(127, SHAPE_BRIGHT);
        set_config(0, 0, 20'hFFFFF);
        send_frame(PIXELS, SHAPE_BRIGHT);
    endtask

    // Random frames over several register settings, one of them at full rate on both sides.
    task automatic test_random_frames();
        int phase_items;
        int phase_frames;
        int len;
        int roll;
        frame_shape_t shape;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_config(THRESHOLD_RESET, START_INDEX_RESET, END_LIMIT_RESET);
                3: set_config(0, 0, 20'hFFFFF);
                4: set_config($urandom_range(0, 4095), $urandom_range(0, 127),
                              $urandom_range(0, 20'hFFFFF));
                default: set_config($urandom_range(0, 800), $urandom_range(0, 8),
                                    $urandom_range(1000, 60000));
            endcase
            steady_rate  = (phase == 2);
            phase_items  = pixels_sent;
            phase_frames = 0;
            while (pixels_sent - phase_items < PHASE_ITEMS || phase_frames < 2)
            begin
                roll = $urandom_range(99);
                len  = (roll < 8) ? $urandom_range(PIXELS + 1, PIXELS + 32) :
                       (roll < 16) ? $urandom_range(100, PIXELS) : $urandom_range(1, 40);
                roll = $urandom_range(99);
                shape = (roll < 60) ? SHAPE_PROFILE : (roll < 80) ? SHAPE_NOISE :
                        (roll < 90) ? SHAPE_DARK : SHAPE_BRIGHT;
                send_frame(len, shape);
                phase_frames++;
            end
            wait_idle();
            steady_rate = 1'b0;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        pixel         = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cfg_threshold = THRESHOLD_RESET;
        cfg_start     = START_INDEX_RESET;
        cfg_limit     = END_LIMIT_RESET;
        px_pos        = 0;
        int_sum       = '0;
        wt_sum        = '0;
        lit_seen      = 1'b0;
        steady_rate   = 1'b0;
        errors        = 0;
        pixels_sent   = 0;
        frames_sent   = 0;
        settings_used = 1;
        lines_seen    = 0;
        none_seen     = 0;
        end_seen      = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_directed_frames();
        test_limit_boundary();
        test_register_extremes();
        test_random_frames();
        wait_idle();

        $display("Sent %0d pixels in %0d frames under %0d register settings.",
                 pixels_sent, frames_sent, settings_used);
        $display("Results checked: %0d line found, %0d no line, %0d end of line.",
                 lines_seen, none_seen, end_seen);
        if (errors == 0)
            $display("line_sensor_centroid_core test passed");
        else
            $display("line_sensor_centroid_core test failed");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("line_sensor_centroid_core test failed");
        $finish;
    end

endmodule
